// ----- design/spss_pkg.sv -----
package spss_pkg;

  localparam int FRAC_BITS = 28;
  localparam int COEF_W    = 32;
  localparam int DIM_W     = 7;
  localparam int FLAT_W    = 17;
  localparam int NUM_TAPS  = 18;
  localparam int TAP_W     = 5;
  localparam int KIND_W    = 2;
  localparam int INDEX_W   = 12;
  localparam int OUT_W     = 32;
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD   = 2'd0,
    KIND_STEP  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_SPARE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_COEF_CENTER      = 3'd0,
    REG_COEF_NEAR        = 3'd1,
    REG_COEF_DIAG        = 3'd2,
    REG_COEF_FAR         = 3'd3,
    REG_COEF_PREV_CENTER = 3'd4,
    REG_COEF_PREV_NEAR   = 3'd5,
    REG_GRID_WIDTH       = 3'd6,
    REG_GRID_HEIGHT      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [COEF_W-1:0] center;
    logic [COEF_W-1:0] near;
    logic [COEF_W-1:0] diag;
    logic [COEF_W-1:0] far;
    logic [COEF_W-1:0] prev_center;
    logic [COEF_W-1:0] prev_near;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
  } cfg_t;

  typedef struct packed {
    logic        prev;
    logic [2:0]  dcol;
    logic [2:0]  drow;
    reg_idx_t    coef;
  } tap_t;

  typedef struct packed {
    logic             clr_wr;
    logic             capture;
    logic             scan_init;
    logic             scan_next;
    logic             tap_issue;
    logic [TAP_W-1:0] tap_idx;
    logic             acc_clr;
    logic             pt_wr;
    logic             add_wr;
    logic             rotate;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_empty;
    logic scan_last;
  } stat_t;

  function automatic tap_t tap_info(input logic [TAP_W-1:0] t);
    tap_t r;
    r = '{prev: 1'b0, dcol: 3'b000, drow: 3'b000, coef: REG_COEF_CENTER};
    case (t)
      5'd0:  r = '{1'b0, 3'b000, 3'b000, REG_COEF_CENTER};
      5'd1:  r = '{1'b0, 3'b001, 3'b000, REG_COEF_NEAR};
      5'd2:  r = '{1'b0, 3'b111, 3'b000, REG_COEF_NEAR};
      5'd3:  r = '{1'b0, 3'b000, 3'b001, REG_COEF_NEAR};
      5'd4:  r = '{1'b0, 3'b000, 3'b111, REG_COEF_NEAR};
      5'd5:  r = '{1'b0, 3'b001, 3'b001, REG_COEF_DIAG};
      5'd6:  r = '{1'b0, 3'b111, 3'b001, REG_COEF_DIAG};
      5'd7:  r = '{1'b0, 3'b001, 3'b111, REG_COEF_DIAG};
      5'd8:  r = '{1'b0, 3'b111, 3'b111, REG_COEF_DIAG};
      5'd9:  r = '{1'b0, 3'b010, 3'b000, REG_COEF_FAR};
      5'd10: r = '{1'b0, 3'b110, 3'b000, REG_COEF_FAR};
      5'd11: r = '{1'b0, 3'b000, 3'b010, REG_COEF_FAR};
      5'd12: r = '{1'b0, 3'b000, 3'b110, REG_COEF_FAR};
      5'd13: r = '{1'b1, 3'b000, 3'b000, REG_COEF_PREV_CENTER};
      5'd14: r = '{1'b1, 3'b001, 3'b000, REG_COEF_PREV_NEAR};
      5'd15: r = '{1'b1, 3'b111, 3'b000, REG_COEF_PREV_NEAR};
      5'd16: r = '{1'b1, 3'b000, 3'b001, REG_COEF_PREV_NEAR};
      5'd17: r = '{1'b1, 3'b000, 3'b111, REG_COEF_PREV_NEAR};
      default: r = '{1'b0, 3'b000, 3'b000, REG_COEF_CENTER};
    endcase
    return r;
  endfunction

endpackage

// ----- design/spss_sat.sv -----
module spss_sat #(
  parameter int IN_W  = 33,
  parameter int OUT_W = 32
) (
  input  logic [IN_W-1:0]  din,
  output logic [OUT_W-1:0] dout,
  output logic             clipped
);

  logic [IN_W-OUT_W:0] top;
  logic                fits;

  assign top     = din[IN_W-1:OUT_W-1];
  assign fits    = (&top) | ~(|top);
  assign clipped = ~fits;
  assign dout    = fits ? din[OUT_W-1:0] : {din[IN_W-1], {(OUT_W-1){~din[IN_W-1]}}};

endmodule

// ----- design/spss_cfg.sv -----
module spss_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [spss_pkg::PADDR_W-1:0] paddr,
  input  logic [spss_pkg::PDATA_W-1:0] pwdata,
  output logic [spss_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output spss_pkg::cfg_t               cfg
);

  spss_pkg::cfg_t     cfg_r;
  spss_pkg::cfg_t     cfg_nxt;
  spss_pkg::reg_idx_t idx;
  logic               wr;

  assign idx    = spss_pkg::reg_idx_t'(paddr[spss_pkg::PADDR_W-1:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        spss_pkg::REG_COEF_CENTER:      cfg_nxt.center      = pwdata;
        spss_pkg::REG_COEF_NEAR:        cfg_nxt.near        = pwdata;
        spss_pkg::REG_COEF_DIAG:        cfg_nxt.diag        = pwdata;
        spss_pkg::REG_COEF_FAR:         cfg_nxt.far         = pwdata;
        spss_pkg::REG_COEF_PREV_CENTER: cfg_nxt.prev_center = pwdata;
        spss_pkg::REG_COEF_PREV_NEAR:   cfg_nxt.prev_near   = pwdata;
        spss_pkg::REG_GRID_WIDTH:       cfg_nxt.width  = pwdata[spss_pkg::DIM_W-1:0];
        spss_pkg::REG_GRID_HEIGHT:      cfg_nxt.height = pwdata[spss_pkg::DIM_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      spss_pkg::REG_COEF_CENTER:      prdata = cfg_r.center;
      spss_pkg::REG_COEF_NEAR:        prdata = cfg_r.near;
      spss_pkg::REG_COEF_DIAG:        prdata = cfg_r.diag;
      spss_pkg::REG_COEF_FAR:         prdata = cfg_r.far;
      spss_pkg::REG_COEF_PREV_CENTER: prdata = cfg_r.prev_center;
      spss_pkg::REG_COEF_PREV_NEAR:   prdata = cfg_r.prev_near;
      spss_pkg::REG_GRID_WIDTH:       prdata = spss_pkg::PDATA_W'(cfg_r.width);
      spss_pkg::REG_GRID_HEIGHT:      prdata = spss_pkg::PDATA_W'(cfg_r.height);
      default:                        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{center: '0, near: '0, diag: '0, far: '0, prev_center: '0,
                 prev_near: '0, width: spss_pkg::DIM_W'(64),
                 height: spss_pkg::DIM_W'(64)};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- design/spss_ctrl.sv -----
module spss_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [spss_pkg::KIND_W-1:0] kind,
  input  spss_pkg::stat_t             stat,
  output spss_pkg::cmd_t              cmd,
  output logic                        busy
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ADD_RD, S_ADD_WR, S_TAP, S_DRAIN, S_PT_WR, S_OUT_RD, S_OUT_WAIT
  } state_t;

  state_t                     state_r, state_nxt;
  logic [spss_pkg::TAP_W-1:0] tap_r, tap_nxt;
  logic                       drain_r, drain_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    tap_nxt   = tap_r;
    drain_nxt = drain_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          case (spss_pkg::kind_t'(kind))
            spss_pkg::KIND_ADD: state_nxt = S_ADD_RD;
            spss_pkg::KIND_STEP: begin
              if (stat.scan_empty) begin
                cmd.rotate = 1'b1;
                state_nxt  = S_OUT_RD;
              end else begin
                cmd.scan_init = 1'b1;
                tap_nxt       = '0;
                state_nxt     = S_TAP;
              end
            end
            default: state_nxt = S_OUT_RD;
          endcase
        end
      end
      S_ADD_RD: state_nxt = S_ADD_WR;
      S_ADD_WR: begin
        cmd.add_wr = 1'b1;
        state_nxt  = S_OUT_RD;
      end
      S_TAP: begin
        cmd.tap_issue = 1'b1;
        cmd.tap_idx   = tap_r;
        cmd.acc_clr   = (tap_r == '0);
        if (tap_r == spss_pkg::TAP_W'(spss_pkg::NUM_TAPS - 1)) begin
          drain_nxt = 1'b0;
          state_nxt = S_DRAIN;
        end else begin
          tap_nxt = tap_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (drain_r) state_nxt = S_PT_WR;
        else drain_nxt = 1'b1;
      end
      S_PT_WR: begin
        cmd.pt_wr = 1'b1;
        if (stat.scan_last) begin
          cmd.rotate = 1'b1;
          state_nxt  = S_OUT_RD;
        end else begin
          cmd.scan_next = 1'b1;
          tap_nxt       = '0;
          state_nxt     = S_TAP;
        end
      end
      S_OUT_RD: state_nxt = S_OUT_WAIT;
      S_OUT_WAIT: begin
        cmd.out_load = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      tap_r   <= '0;
      drain_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
      drain_r <= drain_nxt;
    end
  end

  a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TAP |-> tap_r < spss_pkg::TAP_W'(spss_pkg::NUM_TAPS))
    else $error("tap counter out of range");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT_WAIT |=> state_r == S_IDLE)
    else $error("result not followed by idle");

  a_drain_to_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN && drain_r) |=> state_r == S_PT_WR)
    else $error("drain did not end in point write");

endmodule

// ----- design/spss_dp.sv -----
module spss_dp #(
  parameter int GRID_POINTS = 4096,
  parameter int VALUE_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  spss_pkg::cfg_t               cfg,
  input  spss_pkg::cmd_t               cmd,
  output spss_pkg::stat_t              stat,
  input  logic [spss_pkg::INDEX_W-1:0] in_point_index,
  input  logic [31:0]                  in_add_value,
  output logic                         out_valid,
  output logic [spss_pkg::OUT_W-1:0]   out_displacement,
  output logic                         out_saturated
);

  localparam int ADDR_W = (GRID_POINTS > 1) ? $clog2(GRID_POINTS) : 1;
  localparam int VB     = VALUE_BITS;
  localparam int PROD_W = VB + spss_pkg::COEF_W;
  localparam int ACC_W  = PROD_W + 5;
  localparam int RND_W  = ACC_W - spss_pkg::FRAC_BITS;
  localparam int WIDE_W = (VB > 32) ? VB : 32;
  localparam int SUM_W  = WIDE_W + 1;
  localparam int FW     = spss_pkg::FLAT_W;
  localparam int DW     = spss_pkg::DIM_W;

  logic [spss_pkg::INDEX_W-1:0] idx_r;
  logic [31:0]                  addv_r;
  logic [DW-1:0]                col_r, col_nxt, row_r, row_nxt;
  logic [FW-1:0]                base_r, base_nxt;
  logic [ADDR_W-1:0]            clr_r, clr_nxt;
  logic [1:0]                   rot_r, rot_nxt, nxt_num, prev_num;

  logic [FW-1:0] w_f, p, col_off, row_off, tap_addr, idx_f, rd_addr_f;
  logic          rd_in, pt_in, idx_in;
  spss_pkg::tap_t tap;

  logic [VB-1:0] rd_data [3];
  logic [VB-1:0] wd [3];
  logic          we [3];
  logic [ADDR_W-1:0] wa;

  logic                 rd_oob_r, v1_r, v2_r, s1_prev_r;
  spss_pkg::reg_idx_t   s1_coef_r;
  logic [VB-1:0]        cur_q, prev_q, tap_val;
  logic [31:0]          coef_val;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt, rnd_sum;

  logic [VB-1:0]    pt_val, cur_sum_c, prev_sum_c;
  logic             pt_clip, cur_clip, prev_clip, o_clip;
  logic [SUM_W-1:0] cur_sum, prev_sum;
  logic [WIDE_W-1:0] o_wide;
  logic [31:0]      o_val;
  logic             sat_r, sat_nxt;
  logic             out_valid_r;
  logic [31:0]      out_disp_r;
  logic             out_sat_r;

  function automatic logic [VB-1:0] pick(input logic [1:0] n, input logic [VB-1:0] a,
                                         input logic [VB-1:0] b, input logic [VB-1:0] c);
    logic [VB-1:0] r;
    case (n)
      2'd0:    r = a;
      2'd1:    r = b;
      default: r = c;
    endcase
    return r;
  endfunction

  assign nxt_num  = (rot_r == 2'd2) ? 2'd0 : rot_r + 2'd1;
  assign prev_num = (rot_r == 2'd0) ? 2'd2 : rot_r - 2'd1;

  assign w_f   = FW'(cfg.width);
  assign p     = base_r + FW'(col_r);
  assign tap   = spss_pkg::tap_info(cmd.tap_idx);
  assign col_off = {{(FW-3){tap.dcol[2]}}, tap.dcol};

  always_comb begin
    case (tap.drow)
      3'b001:  row_off = w_f;
      3'b010:  row_off = w_f << 1;
      3'b111:  row_off = -w_f;
      3'b110:  row_off = -(w_f << 1);
      default: row_off = '0;
    endcase
  end

  assign tap_addr  = p + col_off + row_off;
  assign idx_f     = FW'(idx_r);
  assign rd_addr_f = cmd.tap_issue ? tap_addr : idx_f;
  assign rd_in     = rd_addr_f < FW'(GRID_POINTS);
  assign pt_in     = p < FW'(GRID_POINTS);
  assign idx_in    = idx_f < FW'(GRID_POINTS);

  assign stat.clr_last   = (clr_r == ADDR_W'(GRID_POINTS - 1));
  assign stat.scan_empty = (cfg.width < DW'(4)) || (cfg.height < DW'(4));
  assign stat.scan_last  = (col_r == cfg.width - DW'(2)) && (row_r == cfg.height - DW'(2));

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    base_nxt = base_r;
    if (cmd.scan_init) begin
      col_nxt  = DW'(2);
      row_nxt  = DW'(2);
      base_nxt = w_f << 1;
    end else if (cmd.scan_next) begin
      if (col_r == cfg.width - DW'(2)) begin
        col_nxt  = DW'(2);
        row_nxt  = row_r + DW'(1);
        base_nxt = base_r + w_f;
      end else begin
        col_nxt = col_r + DW'(1);
      end
    end
  end

  assign clr_nxt = cmd.clr_wr ? clr_r + ADDR_W'(1) : clr_r;
  assign rot_nxt = cmd.rotate ? nxt_num : rot_r;

  assign cur_q  = rd_oob_r ? '0 : pick(rot_r, rd_data[0], rd_data[1], rd_data[2]);
  assign prev_q = rd_oob_r ? '0 : pick(prev_num, rd_data[0], rd_data[1], rd_data[2]);

  always_comb begin
    case (s1_coef_r)
      spss_pkg::REG_COEF_CENTER:      coef_val = cfg.center;
      spss_pkg::REG_COEF_NEAR:        coef_val = cfg.near;
      spss_pkg::REG_COEF_DIAG:        coef_val = cfg.diag;
      spss_pkg::REG_COEF_FAR:         coef_val = cfg.far;
      spss_pkg::REG_COEF_PREV_CENTER: coef_val = cfg.prev_center;
      spss_pkg::REG_COEF_PREV_NEAR:   coef_val = cfg.prev_near;
      default:                        coef_val = '0;
    endcase
  end

  assign tap_val  = s1_prev_r ? prev_q : cur_q;
  assign prod_nxt = PROD_W'($signed(tap_val)) * PROD_W'($signed(coef_val));

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.acc_clr) acc_nxt = '0;
    else if (v2_r) acc_nxt = acc_r + ACC_W'(prod_r);
  end

  assign rnd_sum = acc_r + (ACC_W'(1) << (spss_pkg::FRAC_BITS - 1));

  spss_sat #(.IN_W(RND_W), .OUT_W(VB)) u_sat_pt (
    .din(rnd_sum[ACC_W-1:spss_pkg::FRAC_BITS]), .dout(pt_val), .clipped(pt_clip));

  assign cur_sum  = SUM_W'($signed(cur_q)) + SUM_W'($signed(addv_r));
  assign prev_sum = SUM_W'($signed(prev_q)) + SUM_W'($signed(addv_r));

  spss_sat #(.IN_W(SUM_W), .OUT_W(VB)) u_sat_cur (
    .din(cur_sum), .dout(cur_sum_c), .clipped(cur_clip));
  spss_sat #(.IN_W(SUM_W), .OUT_W(VB)) u_sat_prev (
    .din(prev_sum), .dout(prev_sum_c), .clipped(prev_clip));

  assign o_wide = WIDE_W'($signed(cur_q));

  spss_sat #(.IN_W(WIDE_W), .OUT_W(32)) u_sat_out (
    .din(o_wide), .dout(o_val), .clipped(o_clip));

  always_comb begin
    sat_nxt = sat_r;
    if (cmd.capture) sat_nxt = 1'b0;
    else if (cmd.add_wr && idx_in) sat_nxt = sat_r | cur_clip | prev_clip;
    else if (cmd.pt_wr && pt_in) sat_nxt = sat_r | pt_clip;
  end

  assign wa = cmd.clr_wr ? clr_r : (cmd.pt_wr ? p[ADDR_W-1:0] : idx_f[ADDR_W-1:0]);

  for (genvar g = 0; g < 3; g++) begin : g_grid
    logic [VB-1:0] grid_r [GRID_POINTS];
    logic [VB-1:0] rd_r;

    always_comb begin
      we[g] = cmd.clr_wr
            | (cmd.pt_wr && pt_in && nxt_num == 2'(g))
            | (cmd.add_wr && idx_in && (rot_r == 2'(g) || prev_num == 2'(g)));
      if (cmd.clr_wr) wd[g] = '0;
      else if (cmd.pt_wr) wd[g] = pt_val;
      else if (rot_r == 2'(g)) wd[g] = cur_sum_c;
      else wd[g] = prev_sum_c;
    end

    always_ff @(posedge clk) begin
      if (we[g]) grid_r[wa] <= wd[g];
      rd_r <= grid_r[rd_addr_f[ADDR_W-1:0]];
    end

    assign rd_data[g] = rd_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r  <= in_point_index;
      addv_r <= in_add_value;
    end
    if (cmd.tap_issue) begin
      s1_prev_r <= tap.prev;
      s1_coef_r <= tap.coef;
    end
    rd_oob_r   <= ~rd_in;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    base_r     <= base_nxt;
    out_disp_r <= o_val;
    out_sat_r  <= sat_r | o_clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      rot_r       <= 2'd0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clr_r       <= clr_nxt;
      rot_r       <= rot_nxt;
      v1_r        <= cmd.tap_issue;
      v2_r        <= v1_r;
      sat_r       <= sat_nxt;
      out_valid_r <= cmd.out_load;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_displacement = out_disp_r;
  assign out_saturated    = out_sat_r;

endmodule

// ----- design/stiff_plate_stencil_step.sv -----
// A read request passes through S_OUT_RD and S_OUT_WAIT before its result is registered; an add
// first reads and writes the point in S_ADD_RD and S_ADD_WR. A time step visits each interior
// point in turn, one memory read per stencil tap plus multiply, accumulate and write.
// One request is in flight at a time; busy stays high until its result strobe.
// After reset a clearing pass zeroes every point of all three grids with busy high.
// The receiver cannot stall: each result is shown for one cycle only.
module stiff_plate_stencil_step #(
  parameter int GRID_POINTS = 4096,
  parameter int VALUE_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_kind,
  input  logic [11:0]                  in_point_index,
  input  logic [31:0]                  in_add_value,
  output logic                         out_valid,
  output logic [31:0]                  out_displacement,
  output logic                         out_saturated,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [spss_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  spss_pkg::cfg_t  cfg;
  spss_pkg::cmd_t  cmd;
  spss_pkg::stat_t stat;

  spss_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg));

  spss_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .kind(in_kind), .stat(stat),
    .cmd(cmd), .busy(busy));

  spss_dp #(.GRID_POINTS(GRID_POINTS), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .cmd(cmd), .stat(stat),
    .in_point_index(in_point_index), .in_add_value(in_add_value),
    .out_valid(out_valid), .out_displacement(out_displacement),
    .out_saturated(out_saturated));

endmodule
